// ===== rtl/hrdc_pkg.sv =====
// Shared constants, types and the hue scaling function of the HSV to RGB converter.
`default_nettype none

package hrdc_pkg;

    // Item operation codes.
    localparam logic OpConvert = 1'b0;
    localparam logic OpLoad    = 1'b1;

    localparam int unsigned SectorDegInt = 60;
    localparam int unsigned CurveDepth   = 256;

    localparam logic [7:0]  FullLevel   = 8'd255;
    localparam logic [8:0]  HueScale    = 9'd359;
    localparam logic [6:0]  SectorDeg   = 7'(SectorDegInt);
    // floor(2^16 / 60); the quotient it gives is at most one below the true one.
    localparam logic [10:0] RecipSector = 11'd1092;

    typedef logic [7:0]  level_t;
    typedef logic [8:0]  deg_t;
    typedef logic [2:0]  sector_t;
    typedef logic [5:0]  pos_t;
    typedef logic [6:0]  ramp_pos_t;
    typedef logic [13:0] prod_t;

    typedef struct packed {
        logic s1_free;
        logic s1_valid;
        logic s2_valid;
        logic s3_valid;
        logic s4_valid;
    } pipe_status_t;

    // Degrees as hue * 359 / 255, with the division done as a reciprocal
    // multiply (x * 257 / 2^16) followed by a single correction step.
    function automatic deg_t hue_to_deg(input level_t hue);
        logic [16:0] scaled;
        logic [24:0] approx;
        deg_t        quot;
        logic [16:0] rem;
        scaled = 17'(hue) * 17'(HueScale);
        approx = (25'(scaled) << 8) + 25'(scaled);
        quot   = approx[24:16];
        rem    = scaled - ((17'(quot) << 8) - 17'(quot));
        if (rem >= 17'(FullLevel))
        begin
            quot = quot + 9'd1;
        end
        return quot;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hrdc_curve_mem.sv =====
// Brightness curve memory: one write port and two registered read ports.
`default_nettype none

module hrdc_curve_mem (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire hrdc_pkg::level_t wr_addr,
    input  wire hrdc_pkg::level_t wr_data,
    input  wire logic            rd_en,
    input  wire hrdc_pkg::level_t rd_addr_a,
    input  wire hrdc_pkg::level_t rd_addr_b,
    output hrdc_pkg::level_t     rd_data_a,
    output hrdc_pkg::level_t     rd_data_b
);
    import hrdc_pkg::*;

    level_t curve_mem [CurveDepth];

    level_t rd_a_reg;
    level_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            curve_mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while the first pipeline stage is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= curve_mem[rd_addr_a];
            rd_b_reg <= curve_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== rtl/hrdc_color_pipe.sv =====
// Colour pipeline: base level, sector split, ramp and channel selection.
`default_nettype none

module hrdc_color_pipe (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 conv_en,
    input  wire hrdc_pkg::deg_t       deg,
    input  wire hrdc_pkg::level_t     curve_v,
    input  wire hrdc_pkg::level_t     curve_cs,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output hrdc_pkg::level_t          red,
    output hrdc_pkg::level_t          green,
    output hrdc_pkg::level_t          blue,
    output hrdc_pkg::pipe_status_t    status
);
    import hrdc_pkg::*;

    localparam deg_t Sec1Start = 9'(1 * SectorDegInt);
    localparam deg_t Sec2Start = 9'(2 * SectorDegInt);
    localparam deg_t Sec3Start = 9'(3 * SectorDegInt);
    localparam deg_t Sec4Start = 9'(4 * SectorDegInt);
    localparam deg_t Sec5Start = 9'(5 * SectorDegInt);

    // Stage 1: curve read data arrives from the memory.
    logic    s1_valid_reg;
    deg_t    s1_deg_reg;

    // Stage 2.
    logic    s2_valid_reg;
    level_t  s2_v_reg;
    level_t  s2_base_reg;
    sector_t s2_sector_reg;
    pos_t    s2_pos_reg;
    logic    s2_gray_reg;

    // Stage 3.
    logic    s3_valid_reg;
    level_t  s3_v_reg;
    level_t  s3_base_reg;
    sector_t s3_sector_reg;
    logic    s3_gray_reg;
    prod_t   s3_prod_reg;

    // Stage 4.
    logic    s4_valid_reg;
    level_t  s4_v_reg;
    level_t  s4_base_reg;
    sector_t s4_sector_reg;
    logic    s4_gray_reg;
    prod_t   s4_prod_reg;
    level_t  s4_quot_reg;

    // Output register.
    logic    out_valid_reg;
    level_t  red_reg;
    level_t  green_reg;
    level_t  blue_reg;

    logic out_en;
    logic s4_en;
    logic s3_en;
    logic s2_en;
    logic s1_en;

    // Each stage moves on when the one after it is empty or moving.
    assign out_en = !out_valid_reg || out_ready;
    assign s4_en  = !s4_valid_reg || out_en;
    assign s3_en  = !s3_valid_reg || s4_en;
    assign s2_en  = !s2_valid_reg || s3_en;
    assign s1_en  = !s1_valid_reg || s2_en;

    // Stage 1 logic.
    logic [15:0] base_prod;
    level_t      s2_base_next;
    logic        s2_gray_next;
    sector_t     s2_sector_next;
    deg_t        sector_start;
    pos_t        s2_pos_next;

    always_comb
    begin
        // (255 - s) equals the raw curve entry read at the inverted saturation.
        base_prod    = 16'(curve_cs) * 16'(curve_v);
        s2_base_next = base_prod[15:8];
        s2_gray_next = (curve_cs == FullLevel);
        if (s1_deg_reg >= Sec5Start)
        begin
            s2_sector_next = 3'd5;
            sector_start   = Sec5Start;
        end
        else if (s1_deg_reg >= Sec4Start)
        begin
            s2_sector_next = 3'd4;
            sector_start   = Sec4Start;
        end
        else if (s1_deg_reg >= Sec3Start)
        begin
            s2_sector_next = 3'd3;
            sector_start   = Sec3Start;
        end
        else if (s1_deg_reg >= Sec2Start)
        begin
            s2_sector_next = 3'd2;
            sector_start   = Sec2Start;
        end
        else if (s1_deg_reg >= Sec1Start)
        begin
            s2_sector_next = 3'd1;
            sector_start   = Sec1Start;
        end
        else
        begin
            s2_sector_next = 3'd0;
            sector_start   = 9'd0;
        end
        s2_pos_next = 6'(s1_deg_reg - sector_start);
    end

    // Stage 2 logic: odd sectors ramp downwards.
    ramp_pos_t   ramp_x;
    level_t      diff;
    logic [14:0] ramp_prod;
    prod_t       s3_prod_next;

    always_comb
    begin
        ramp_x       = s2_sector_reg[0] ? (SectorDeg - 7'(s2_pos_reg)) : 7'(s2_pos_reg);
        diff         = s2_v_reg - s2_base_reg;
        ramp_prod    = 15'(diff) * 15'(ramp_x);
        s3_prod_next = ramp_prod[13:0];
    end

    // Stage 3 logic: first estimate of the product divided by 60.
    logic [23:0] recip_prod;
    level_t      s4_quot_next;

    always_comb
    begin
        recip_prod   = 24'(s3_prod_reg) * 24'(RecipSector);
        s4_quot_next = recip_prod[23:16];
    end

    // Stage 4 logic: quotient correction and channel selection.
    prod_t  rem;
    level_t quot;
    level_t ramp;
    level_t red_next;
    level_t green_next;
    level_t blue_next;

    always_comb
    begin
        rem  = s4_prod_reg - ((14'(s4_quot_reg) << 6) - (14'(s4_quot_reg) << 2));
        quot = s4_quot_reg + ((rem >= 14'(SectorDeg)) ? 8'd1 : 8'd0);
        ramp = quot + s4_base_reg;
        case (s4_sector_reg)
            3'd0:
            begin
                red_next   = s4_v_reg;
                green_next = ramp;
                blue_next  = s4_base_reg;
            end
            3'd1:
            begin
                red_next   = ramp;
                green_next = s4_v_reg;
                blue_next  = s4_base_reg;
            end
            3'd2:
            begin
                red_next   = s4_base_reg;
                green_next = s4_v_reg;
                blue_next  = ramp;
            end
            3'd3:
            begin
                red_next   = s4_base_reg;
                green_next = ramp;
                blue_next  = s4_v_reg;
            end
            3'd4:
            begin
                red_next   = ramp;
                green_next = s4_base_reg;
                blue_next  = s4_v_reg;
            end
            default:
            begin
                red_next   = s4_v_reg;
                green_next = s4_base_reg;
                blue_next  = ramp;
            end
        endcase
        if (s4_gray_reg)
        begin
            red_next   = s4_v_reg;
            green_next = s4_v_reg;
            blue_next  = s4_v_reg;
        end
    end

    // Valid chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= conv_en;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (conv_en)
        begin
            s1_deg_reg <= deg;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_v_reg      <= curve_v;
            s2_base_reg   <= s2_base_next;
            s2_sector_reg <= s2_sector_next;
            s2_pos_reg    <= s2_pos_next;
            s2_gray_reg   <= s2_gray_next;
        end
        if (s3_en && s2_valid_reg)
        begin
            s3_v_reg      <= s2_v_reg;
            s3_base_reg   <= s2_base_reg;
            s3_sector_reg <= s2_sector_reg;
            s3_gray_reg   <= s2_gray_reg;
            s3_prod_reg   <= s3_prod_next;
        end
        if (s4_en && s3_valid_reg)
        begin
            s4_v_reg      <= s3_v_reg;
            s4_base_reg   <= s3_base_reg;
            s4_sector_reg <= s3_sector_reg;
            s4_gray_reg   <= s3_gray_reg;
            s4_prod_reg   <= s3_prod_reg;
            s4_quot_reg   <= s4_quot_next;
        end
        if (out_en && s4_valid_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    assign status.s1_free  = s1_en;
    assign status.s1_valid = s1_valid_reg;
    assign status.s2_valid = s2_valid_reg;
    assign status.s3_valid = s3_valid_reg;
    assign status.s4_valid = s4_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_dim_curve_unit.sv =====
// Top level of the HSV to RGB converter with a loadable brightness curve.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | operation, hue, saturation, brightness,
//          |                      | curve_index, curve_value
//  out     | out_valid / out_ready| red, green, blue
//
// One item is taken per clock while in_ready is high. A convert item is registered first
// by the curve read at the accepting edge, then passes through three arithmetic
// stages and the output register.
// A load item writes the curve memory in the cycle it is accepted and gives no result.
// Reset clears only the pipeline valid bits; curve entries hold nothing until loaded.
// A stalled output lets the earlier stages close up their bubbles before in_ready drops.
`default_nettype none

module hsv_to_rgb_dim_curve_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             operation,
    input  wire hrdc_pkg::level_t hue,
    input  wire hrdc_pkg::level_t saturation,
    input  wire hrdc_pkg::level_t brightness,
    input  wire hrdc_pkg::level_t curve_index,
    input  wire hrdc_pkg::level_t curve_value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hrdc_pkg::level_t      red,
    output hrdc_pkg::level_t      green,
    output hrdc_pkg::level_t      blue
);
    import hrdc_pkg::*;

    logic         accept;
    logic         load_en;
    logic         conv_en;
    deg_t         deg;
    level_t       curve_v;
    level_t       curve_cs;
    pipe_status_t status;

    assign accept  = in_valid && in_ready;
    assign load_en = accept && (operation == OpLoad);
    assign conv_en = accept && (operation == OpConvert);
    assign deg     = hue_to_deg(hue);
    assign in_ready = status.s1_free;

    // Writes and reads belong to different accepted items, so a read always
    // sees every earlier load without any forwarding.
    hrdc_curve_mem u_curve_mem (
        .clk       (clk),
        .wr_en     (load_en),
        .wr_addr   (curve_index),
        .wr_data   (curve_value),
        .rd_en     (conv_en),
        .rd_addr_a (brightness),
        .rd_addr_b (FullLevel - saturation),
        .rd_data_a (curve_v),
        .rd_data_b (curve_cs)
    );

    hrdc_color_pipe u_color_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv_en   (conv_en),
        .deg       (deg),
        .curve_v   (curve_v),
        .curve_cs  (curve_cs),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .status    (status)
    );

    // Input stalls only when every stage and the output register are full.
    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && status.s1_valid && status.s2_valid
                       && status.s3_valid && status.s4_valid)
    ) else $error("input stalled while the pipeline had room");

    a_convert_enters: assert property (
        @(posedge clk) disable iff (!rst_n)
        conv_en |=> status.s1_valid
    ) else $error("accepted convert item did not enter the pipeline");

    a_load_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        load_en |=> !status.s1_valid
    ) else $error("load item entered the colour pipeline");

    a_result_from_stage4: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(status.s4_valid)
    ) else $error("result appeared without a stage four item");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for hsv_to_rgb_dim_curve_unit with random idling and back-pressure.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrdc_pkg::level_t;
    import hrdc_pkg::OpConvert;
    import hrdc_pkg::OpLoad;

    localparam int unsigned HueSpan     = 359;
    localparam int unsigned LevelMax    = 255;
    localparam int unsigned SectorWidth = 60;
    localparam int unsigned ShowLimit   = 10;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } rgb_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   in_valid    = 1'b0;
    logic   operation   = OpConvert;
    level_t hue         = '0;
    level_t saturation  = '0;
    level_t brightness  = '0;
    level_t curve_index = '0;
    level_t curve_value = '0;
    logic   out_ready   = 1'b0;
    logic   in_ready;
    logic   out_valid;
    level_t red;
    level_t green;
    level_t blue;

    level_t      curve_shadow [256];
    rgb_t        expected_pixels [$];
    int unsigned mismatch_count = 0;
    int unsigned send_gap_max   = 6;
    int unsigned recv_gap_max   = 6;
    int unsigned hold_request   = 0;

    hsv_to_rgb_dim_curve_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness),
        .curve_index (curve_index),
        .curve_value (curve_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    always #1 clk = ~clk;

    function automatic int unsigned ramp_level(input int unsigned v, input int unsigned base,
                                               input int unsigned x);
        return ((v - base) * x) / SectorWidth + base;
    endfunction

    function automatic rgb_t predict_pixel(input level_t hue_in, input level_t sat_in,
                                           input level_t val_in);
        int unsigned deg;
        int unsigned v;
        int unsigned s;
        int unsigned base;
        int unsigned pos;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        deg = (int'(hue_in) * HueSpan) / LevelMax;
        v   = curve_shadow[val_in];
        // Saturation is looked up at the inverted index, and the entry is inverted back.
        s   = LevelMax - int'(curve_shadow[~sat_in]);
        if (s == 0)
        begin
            r = v;
            g = v;
            b = v;
        end
        else
        begin
            base = ((LevelMax - s) * v) >> 8;
            pos  = deg % SectorWidth;
            case (deg / SectorWidth)
                0:       begin r = v; g = ramp_level(v, base, pos); b = base; end
                1:       begin r = ramp_level(v, base, SectorWidth - pos); g = v; b = base; end
                2:       begin r = base; g = v; b = ramp_level(v, base, pos); end
                3:       begin r = base; g = ramp_level(v, base, SectorWidth - pos); b = v; end
                4:       begin r = ramp_level(v, base, pos); g = base; b = v; end
                default: begin r = v; g = base; b = ramp_level(v, base, SectorWidth - pos); end
            endcase
        end
        return '{red: level_t'(r), green: level_t'(g), blue: level_t'(b)};
    endfunction

    // Levels lean towards the extremes so that gray pixels and full saturation turn up often.
    function automatic level_t rand_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return level_t'($urandom);
        endcase
    endfunction

    // Follows every accepted item in order, so the curve copy matches what the block holds.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (operation == OpLoad)
            begin
                curve_shadow[curve_index] = curve_value;
            end
            else
            begin
                expected_pixels.push_back(predict_pixel(hue, saturation, brightness));
            end
        end
    end

    always @(posedge clk)
    begin
        rgb_t got;
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{red: red, green: green, blue: blue};
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= ShowLimit)
                begin
                    $display("%0t: pixel error, no result expected, got r=%0d g=%0d b=%0d",
                             $realtime, got.red, got.green, got.blue);
                end
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
                begin
                    mismatch_count++;
                    if (mismatch_count <= ShowLimit)
                    begin
                        $display("%0t: pixel error, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 $realtime, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    // Output side: a random stall before each result, plus an occasional long hold-off.
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            stall = $urandom_range(0, recv_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Valid stays high after acceptance; the next call either replaces the item in the same
    // step or lowers valid for its gap, so an item is never offered twice.
    task automatic send_item(input logic op, input level_t h, input level_t s, input level_t b,
                             input level_t ci, input level_t cv);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        hue         <= h;
        saturation  <= s;
        brightness  <= b;
        curve_index <= ci;
        curve_value <= cv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic load_curve(input level_t idx, input level_t val);
        send_item(OpLoad, level_t'($urandom), level_t'($urandom), level_t'($urandom), idx, val);
    endtask

    task automatic convert_pixel(input level_t h, input level_t s, input level_t b);
        send_item(OpConvert, h, s, b, level_t'($urandom), level_t'($urandom));
    endtask

    // Also allows for a trailing load item still in flight once the last result is in.
    // The first edge lets the last accepted item reach the expected queue.
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_directed();
        load_curve(8'd255, 8'd255);
        load_curve(8'd0,   8'd0);
        load_curve(8'd200, 8'd180);
        load_curve(8'd55,  8'd90);
        load_curve(8'd128, 8'd255);
        load_curve(8'd127, 8'd7);
        // Full saturation and brightness at both ends of the hue circle.
        convert_pixel(8'd0,   8'd255, 8'd255);
        convert_pixel(8'd255, 8'd255, 8'd255);
        // Hues on either side of the sector boundaries.
        convert_pixel(8'd42,  8'd200, 8'd200);
        convert_pixel(8'd43,  8'd200, 8'd200);
        convert_pixel(8'd85,  8'd200, 8'd200);
        convert_pixel(8'd86,  8'd200, 8'd200);
        convert_pixel(8'd128, 8'd200, 8'd200);
        convert_pixel(8'd170, 8'd200, 8'd200);
        convert_pixel(8'd213, 8'd200, 8'd200);
        convert_pixel(8'd255, 8'd200, 8'd200);
        // Zero curved saturation gives a gray pixel whatever the hue; then zero brightness and mid levels.
        convert_pixel(8'd100, 8'd0,   8'd200);
        convert_pixel(8'd7,   8'd255, 8'd0);
        convert_pixel(8'd150, 8'd128, 8'd128);
        // An entry rewritten just before it is read.
        load_curve(8'd200, 8'd17);
        convert_pixel(8'd60,  8'd200, 8'd200);
        load_curve(8'd255, 8'd0);
        convert_pixel(8'd100, 8'd0,   8'd255);
        pause_until_drained();
    endtask

    // Writes every curve entry once, in shuffled order, so any later pixel reads only
    // entries that hold a value.
    task automatic test_curve_fill();
        level_t order [256];
        level_t tmp;
        int unsigned j;
        for (int i = 0; i < 256; i++)
        begin
            order[i] = level_t'(i);
        end
        for (int i = 255; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
        begin
            load_curve(order[i], rand_level());
        end
        pause_until_drained();
    endtask

    task automatic send_random_items(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                load_curve(level_t'($urandom), rand_level());
            end
            else
            begin
                convert_pixel(level_t'($urandom), rand_level(), rand_level());
            end
        end
    endtask

    task automatic test_full_rate();
        send_gap_max = 0;
        recv_gap_max = 0;
        send_random_items(300);
        pause_until_drained();
        send_gap_max = 6;
        recv_gap_max = 6;
    endtask

    task automatic test_backpressure();
        send_gap_max = 0;
        hold_request = 80;
        for (int i = 0; i < 48; i++)
        begin
            convert_pixel(level_t'($urandom), rand_level(), rand_level());
        end
        pause_until_drained();
        send_gap_max = 6;
    endtask

    task automatic test_random_mix();
        for (int round = 0; round < 7; round++)
        begin
            send_random_items(190);
            pause_until_drained();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_curve_fill();
        test_full_rate();
        test_backpressure();
        test_random_mix();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== hsv_to_rgb_dim_curve_unit.f =====
rtl/hrdc_pkg.sv
rtl/hrdc_curve_mem.sv
rtl/hrdc_color_pipe.sv
rtl/hsv_to_rgb_dim_curve_unit.sv
dv/testbench.sv
